[design/ushe_pkg.sv]
// ----------------------------------------------------------------------------
// ushe_pkg - shared definitions for the URL scheme and host extractor
// Phase codes, status codes, character constants and stream widths.
// ----------------------------------------------------------------------------
package ushe_pkg;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    // Result field widths
    localparam int STATUS_W     = 3;
    localparam int HOST_START_W = 14;
    localparam int HOST_LEN_W   = 14;
    localparam int PATH_START_W = 15;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_SCHEME = 6'b000001,
        PH_COLON  = 6'b000010,
        PH_SLASH  = 6'b000100,
        PH_HOST   = 6'b001000,
        PH_PORT   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_SCHEME = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SCHEME   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_COLON    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SLASHES  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY_HOST   = 3'd5;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;

    // Default line limit
    localparam int MAX_LINE_DEF = 16384;

    // Expected scheme character at a given offset of "https"
    // (the first four also spell "http")
    function automatic logic [7:0] scheme_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h68;  // h
            3'd1:    c = 8'h74;  // t
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h70;  // p
            3'd4:    c = 8'h73;  // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[design/url_scheme_host_extractor.sv]
// ----------------------------------------------------------------------------
// url_scheme_host_extractor - find scheme, host and path of a request line
// Streams one character per transaction and reports one verdict per line.
// ----------------------------------------------------------------------------
// The block takes one character per cycle on the input stream, with tlast on
// the final character of a line, and issues one result transaction per line
// once that final character is accepted and parsed. Each character passes an
// input register, then one step of the parse state machine that also loads
// the result register at end of line; the input side stalls only when a
// finished result is still held in the result register and the next line's
// final character wants to replace it. Status 0 means an exact http or https
// scheme (any case), one colon, two slashes and a non-empty host; host and
// path fields are zero for any other status. Positions saturate at MAX_LINE.
module url_scheme_host_extractor #(
    parameter int MAX_LINE = ushe_pkg::MAX_LINE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [7:0] ch
    input  logic [ushe_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: [2:0] status, [16:3] host_start, [30:17] host_length,
    //          [45:31] path_start, [47:46] zero
    output logic [ushe_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import ushe_pkg::*;

    localparam int PW = $clog2(MAX_LINE + 1);  // position, path start
    localparam int HW = $clog2(MAX_LINE);      // host start, host length
    localparam logic [PW-1:0] POS_MAX  = PW'(MAX_LINE);
    localparam logic [PW-1:0] POS_HMAX = PW'(MAX_LINE - 1);
    localparam logic [HW-1:0] HOST_MAX = HW'(MAX_LINE - 1);

    // Input register
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       in_valid_reg;

    // Parse state
    phase_t        phase_reg,  phase_next;
    logic [PW-1:0] pos_reg,    pos_next;
    logic [2:0]    scount_reg, scount_next;
    logic [1:0]    flags_reg,  flags_next;
    logic [1:0]    slash_reg,  slash_next;
    logic [HW-1:0] hb_reg,     hb_next;
    logic [HW-1:0] hl_reg,     hl_next;
    logic [PW-1:0] pb_reg,     pb_next;
    logic [2:0]    err_reg,    err_next;

    // Result register
    logic [M_TDATA_W-1:0] res_reg, res_next;
    logic                 out_valid_reg;

    logic proc_go;
    logic proc_fire;

    // The parse step may run unless it would overwrite a held result
    assign proc_go   = !last_reg || !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && proc_go;
    assign s_tready  = !in_valid_reg || proc_go;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_go) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            ch_reg   <= s_tdata[7:0];
            last_reg <= s_tlast;
        end
    end

    // Parse step: character update, then end-of-line verdict
    always_comb begin
        logic [7:0]    lc;
        logic [PW-1:0] pos_inc;
        logic [PW-1:0] eol_pos;
        logic          zero_end;
        logic          eol;
        logic          sch_ok;
        logic [31:0]   hb_ext;
        logic [31:0]   hl_ext;
        logic [31:0]   pb_ext;

        phase_next  = phase_reg;
        scount_next = scount_reg;
        flags_next  = flags_reg;
        slash_next  = slash_reg;
        hb_next     = hb_reg;
        hl_next     = hl_reg;
        pb_next     = pb_reg;
        err_next    = err_reg;
        res_next    = res_reg;
        sch_ok      = 1'b0;

        lc = ((ch_reg >= CH_UC_A) && (ch_reg <= CH_UC_Z)) ? (ch_reg | CH_CASE) : ch_reg;
        pos_inc  = (pos_reg < POS_MAX) ? pos_reg + PW'(1) : pos_reg;
        zero_end = (phase_reg != PH_DONE) && (ch_reg == CH_NUL);
        eol      = zero_end || last_reg;
        eol_pos  = zero_end ? pos_reg : pos_inc;

        // Character step; a zero byte only triggers the verdict below
        if (!zero_end) begin
            sch_ok = ((scount_reg == 3'd4) && flags_reg[0])
                  || ((scount_reg == 3'd5) && flags_reg[1]);
            case (phase_reg)
                PH_SCHEME: begin
                    if (ch_reg == CH_COLON) begin
                        if (scount_reg == 3'd0) begin
                            err_next   = ST_EMPTY_SCHEME;
                            phase_next = PH_DONE;
                        end else if (!sch_ok) begin
                            err_next   = ST_BAD_SCHEME;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_COLON;
                        end
                    end else begin
                        if (!((scount_reg < 3'd4) && (lc == scheme_char(scount_reg))))
                            flags_next[0] = 1'b0;
                        if (!((scount_reg < 3'd5) && (lc == scheme_char(scount_reg))))
                            flags_next[1] = 1'b0;
                        if (scount_reg != 3'd7)
                            scount_next = scount_reg + 3'd1;
                    end
                end
                PH_COLON, PH_SLASH: begin
                    if ((phase_reg == PH_COLON) && (ch_reg == CH_COLON)) begin
                        err_next   = ST_BAD_COLON;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_SLASH;
                        if (slash_reg < 2'd2) begin
                            if (ch_reg == CH_SLASH) begin
                                slash_next = slash_reg + 2'd1;
                            end else begin
                                err_next   = ST_BAD_SLASHES;
                                phase_next = PH_DONE;
                            end
                        end else if (ch_reg == CH_SLASH) begin
                            err_next   = ST_BAD_SLASHES;
                            phase_next = PH_DONE;
                        end else if ((ch_reg == CH_COLON) || (ch_reg == CH_SPACE)) begin
                            err_next   = ST_EMPTY_HOST;
                            phase_next = PH_DONE;
                        end else begin
                            hb_next    = (pos_reg < POS_HMAX) ? pos_reg[HW-1:0] : HOST_MAX;
                            hl_next    = HW'(1);
                            phase_next = PH_HOST;
                        end
                    end
                end
                PH_HOST: begin
                    if (ch_reg == CH_COLON) begin
                        pb_next    = pos_reg;
                        phase_next = PH_PORT;
                    end else if ((ch_reg == CH_SLASH) || (ch_reg == CH_SPACE)) begin
                        pb_next    = pos_reg;
                        err_next   = ST_OK;
                        phase_next = PH_DONE;
                    end else if (hl_reg < HOST_MAX) begin
                        hl_next = hl_reg + HW'(1);
                    end
                end
                PH_PORT: begin
                    if ((ch_reg == CH_SLASH) || (ch_reg == CH_SPACE)) begin
                        pb_next    = pos_reg;
                        err_next   = ST_OK;
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // End-of-line verdict on the updated state
        if (eol) begin
            sch_ok = ((scount_next == 3'd4) && flags_next[0])
                  || ((scount_next == 3'd5) && flags_next[1]);
            case (phase_next)
                PH_SCHEME: begin
                    if (scount_next == 3'd0)
                        err_next = ST_EMPTY_SCHEME;
                    else if (sch_ok)
                        err_next = ST_BAD_COLON;
                    else
                        err_next = ST_BAD_SCHEME;
                    phase_next = PH_DONE;
                end
                PH_COLON: begin
                    err_next   = ST_BAD_SLASHES;
                    phase_next = PH_DONE;
                end
                PH_SLASH: begin
                    err_next   = (slash_next < 2'd2) ? ST_BAD_SLASHES : ST_EMPTY_HOST;
                    phase_next = PH_DONE;
                end
                PH_HOST, PH_PORT: begin
                    pb_next    = eol_pos;
                    err_next   = ST_OK;
                    phase_next = PH_DONE;
                end
                default: begin
                end
            endcase
        end

        // Result word, host and path fields zero unless ok
        hb_ext = 32'(hb_next);
        hl_ext = 32'(hl_next);
        pb_ext = 32'(pb_next);
        res_next = '0;
        res_next[2:0] = err_next;
        if (err_next == ST_OK) begin
            res_next[16:3]  = hb_ext[HOST_START_W-1:0];
            res_next[30:17] = hl_ext[HOST_LEN_W-1:0];
            res_next[45:31] = pb_ext[PATH_START_W-1:0];
        end

        pos_next = pos_inc;

        // A flagged character closes the line and restarts the parse
        if (last_reg) begin
            phase_next  = PH_SCHEME;
            pos_next    = '0;
            scount_next = '0;
            flags_next  = 2'b11;
            slash_next  = '0;
            hb_next     = '0;
            hl_next     = '0;
            pb_next     = '0;
            err_next    = ST_OK;
        end
    end

    // Parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SCHEME;
            pos_reg    <= '0;
            scount_reg <= '0;
            flags_reg  <= 2'b11;
            slash_reg  <= '0;
            hb_reg     <= '0;
            hl_reg     <= '0;
            pb_reg     <= '0;
            err_reg    <= ST_OK;
        end else if (proc_fire) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            scount_reg <= scount_next;
            flags_reg  <= flags_next;
            slash_reg  <= slash_next;
            hb_reg     <= hb_next;
            hl_reg     <= hl_next;
            pb_reg     <= pb_next;
            err_reg    <= err_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc_fire && last_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_tdata  = res_reg;
    assign m_tvalid = out_valid_reg;

endmodule
